@@ rtl/gsac_pkg.sv @@
`timescale 1ns / 1ps
// gsac_pkg: shared constants, types and helpers for the grid scc counter
// no dependencies

package gsac_pkg;

    localparam int MAX_SIDE = 64;
    localparam int SIDE_W   = $clog2(MAX_SIDE);
    localparam int ADDR_W   = 2 * SIDE_W;
    localparam int CELLS    = MAX_SIDE * MAX_SIDE;
    localparam int CNT_W    = ADDR_W + 1;
    localparam int CFG_W    = 7;
    localparam int HGT_W    = 16;
    localparam int FIELD_W  = 13;
    localparam int DIR_W    = 3;

    localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd0;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd1;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd2;
    localparam logic [DIR_W-1:0] DIR_UP    = 3'd3;
    localparam logic [DIR_W-1:0] DIR_END   = 3'd4;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_LENGTH = 1'b1;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [HGT_W-1:0]  data;
    } t_load;

    typedef struct packed {
        logic [SIDE_W-1:0] wlast;
        logic [SIDE_W-1:0] llast;
    } t_dims;

    // last index along one side, with out-of-range sizes clamped
    function automatic logic [SIDE_W-1:0] dim_last(input logic [CFG_W-1:0] v);
        logic [SIDE_W-1:0] r;
        if (v == '0) begin
            r = '0;
        end else if (int'(v) > MAX_SIDE) begin
            r = SIDE_W'(MAX_SIDE - 1);
        end else begin
            r = SIDE_W'(v - CFG_W'(1));
        end
        return r;
    endfunction

endpackage

@@ rtl/grid_scc_augmentation_count.sv @@
`timescale 1ns / 1ps
// grid_scc_augmentation_count: top level with register port and cell loader
// depends on gsac_pkg and gsac_core

// Heights are taken one per cycle while o_stall is low and are written straight into
// the height memory in row-major order. The request that carries the last cell
// starts the search, and o_stall stays high until the result has been taken. The
// search begins with a clearing sweep over all 4096 entries of the mark and
// edge-flag memories, then walks every cell and edge on simple dual-port memories
// with one read per cycle: each directed edge is checked in the scc walk and again
// in the marking pass.

module grid_scc_augmentation_count (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [gsac_pkg::HGT_W-1:0]   i_height,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [gsac_pkg::FIELD_W-1:0] o_edges_needed,
    output logic [gsac_pkg::FIELD_W-1:0] o_component_count
);

    localparam int SW = gsac_pkg::SIDE_W;

    logic [gsac_pkg::CFG_W-1:0] r_gw, r_gl;
    logic [SW-1:0]              r_lrow, r_lcol;
    logic                       busy, wr, acc, last;
    gsac_pkg::t_dims            dims;
    gsac_pkg::t_load            load;

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite & (paddr[1:0] == 2'b00);
    assign prdata = (paddr[2] == gsac_pkg::REG_LENGTH) ? 32'(r_gl) : 32'(r_gw);

    assign dims.wlast = gsac_pkg::dim_last(r_gw);
    assign dims.llast = gsac_pkg::dim_last(r_gl);

    assign o_stall   = busy;
    assign acc       = i_valid & ~busy;
    assign last      = (r_lrow == dims.llast) && (r_lcol == dims.wlast);
    assign load.we   = acc;
    assign load.addr = {r_lrow, r_lcol};
    assign load.data = i_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gw   <= gsac_pkg::CFG_W'(1);
            r_gl   <= gsac_pkg::CFG_W'(1);
            r_lrow <= '0;
            r_lcol <= '0;
        end else if (wr) begin
            if (paddr[2] == gsac_pkg::REG_WIDTH) begin
                r_gw <= pwdata[gsac_pkg::CFG_W-1:0];
            end else begin
                r_gl <= pwdata[gsac_pkg::CFG_W-1:0];
            end
            r_lrow <= '0;
            r_lcol <= '0;
        end else if (acc) begin
            if (last) begin
                r_lrow <= '0;
                r_lcol <= '0;
            end else if (r_lcol == dims.wlast) begin
                r_lcol <= '0;
                r_lrow <= r_lrow + SW'(1);
            end else begin
                r_lcol <= r_lcol + SW'(1);
            end
        end
    end

    gsac_core u_core (
        .i_clk,
        .i_rst_n,
        .i_load            (load),
        .i_start           (acc & last),
        .i_dims            (dims),
        .i_stall,
        .o_busy            (busy),
        .o_valid,
        .o_edges_needed,
        .o_component_count
    );

endmodule

@@ rtl/gsac_ram.sv @@
`timescale 1ns / 1ps
// gsac_ram: simple dual-port ram, one write and one registered read port
// no dependencies

module gsac_ram #(
    parameter int DW = 16,
    parameter int AW = 12
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [0:(1<<AW)-1];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/gsac_core.sv @@
`timescale 1ns / 1ps
// gsac_core: walk sequencer, tarjan scc search, edge marking and counting
// depends on gsac_pkg and gsac_ram

module gsac_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  gsac_pkg::t_load              i_load,
    input  logic                         i_start,
    input  gsac_pkg::t_dims              i_dims,
    input  logic                         i_stall,
    output logic                         o_busy,
    output logic                         o_valid,
    output logic [gsac_pkg::FIELD_W-1:0] o_edges_needed,
    output logic [gsac_pkg::FIELD_W-1:0] o_component_count
);

    localparam int AW = gsac_pkg::ADDR_W;
    localparam int CW = gsac_pkg::CNT_W;
    localparam int SW = gsac_pkg::SIDE_W;
    localparam int HW = gsac_pkg::HGT_W;
    localparam int DW = gsac_pkg::DIR_W;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_CLR    = 5'd1;
    localparam logic [4:0] S_OUTER  = 5'd2;
    localparam logic [4:0] S_OUTER2 = 5'd3;
    localparam logic [4:0] S_TOP    = 5'd4;
    localparam logic [4:0] S_H1     = 5'd5;
    localparam logic [4:0] S_H2     = 5'd6;
    localparam logic [4:0] S_V      = 5'd7;
    localparam logic [4:0] S_P1     = 5'd8;
    localparam logic [4:0] S_POPC   = 5'd9;
    localparam logic [4:0] S_POPC2  = 5'd10;
    localparam logic [4:0] S_PAR    = 5'd11;
    localparam logic [4:0] S_PAR2   = 5'd12;
    localparam logic [4:0] S_PAR3   = 5'd13;
    localparam logic [4:0] S_E0     = 5'd14;
    localparam logic [4:0] S_E1     = 5'd15;
    localparam logic [4:0] S_E2     = 5'd16;
    localparam logic [4:0] S_CNT    = 5'd17;
    localparam logic [4:0] S_CNT2   = 5'd18;
    localparam logic [4:0] S_OUT    = 5'd19;

    localparam logic [1:0] MARK_NEW  = 2'd0;
    localparam logic [1:0] MARK_ON   = 2'd1;
    localparam logic [1:0] MARK_DONE = 2'd2;

    logic [4:0]    r_st, n_st;
    logic [SW-1:0] r_srow, n_srow, r_scol, n_scol;
    logic          r_sdone, n_sdone;
    logic [CW-1:0] r_cnt, n_cnt, r_ncomp, n_ncomp, r_sp, n_sp, r_cp, n_cp;
    logic [CW-1:0] r_ca, n_ca, r_p, n_p, r_q, n_q, r_lu, n_lu, r_cu, n_cu;
    logic [AW-1:0] r_u, n_u, r_v, n_v;
    logic [DW-1:0] r_d, n_d;
    logic [HW-1:0] r_hu, n_hu;
    logic [CW-1:0] r_need, n_need;

    // ram ports
    logic          h_we, dc_we, lo_we, mk_we, cm_we, cs_we, ca_we, hi_we, ho_we;
    logic [AW-1:0] h_wa, dc_wa, lo_wa, mk_wa, cm_wa, cs_wa, ca_wa, hi_wa, ho_wa;
    logic [AW-1:0] h_ra, dc_ra, lo_ra, mk_ra, cm_ra, cs_ra, ca_ra, hi_ra, ho_ra;
    logic [HW-1:0] h_wd, h_rd;
    logic [CW-1:0] dc_wd, dc_rd, lo_wd, lo_rd, cm_wd, cm_rd;
    logic [1:0]    mk_wd, mk_rd;
    logic [AW-1:0] cs_wd, cs_rd;
    logic [AW+DW-1:0] ca_wd, ca_rd;
    logic          hi_wd, ho_wd, hi_rd, ho_rd;

    gsac_ram #(.DW(HW), .AW(AW)) u_hgt (.i_clk, .i_we(h_we), .i_waddr(h_wa),
        .i_wdata(h_wd), .i_raddr(h_ra), .o_rdata(h_rd));
    gsac_ram #(.DW(CW), .AW(AW)) u_disc (.i_clk, .i_we(dc_we), .i_waddr(dc_wa),
        .i_wdata(dc_wd), .i_raddr(dc_ra), .o_rdata(dc_rd));
    gsac_ram #(.DW(CW), .AW(AW)) u_low (.i_clk, .i_we(lo_we), .i_waddr(lo_wa),
        .i_wdata(lo_wd), .i_raddr(lo_ra), .o_rdata(lo_rd));
    gsac_ram #(.DW(2), .AW(AW)) u_mark (.i_clk, .i_we(mk_we), .i_waddr(mk_wa),
        .i_wdata(mk_wd), .i_raddr(mk_ra), .o_rdata(mk_rd));
    gsac_ram #(.DW(CW), .AW(AW)) u_comp (.i_clk, .i_we(cm_we), .i_waddr(cm_wa),
        .i_wdata(cm_wd), .i_raddr(cm_ra), .o_rdata(cm_rd));
    gsac_ram #(.DW(AW), .AW(AW)) u_cstk (.i_clk, .i_we(cs_we), .i_waddr(cs_wa),
        .i_wdata(cs_wd), .i_raddr(cs_ra), .o_rdata(cs_rd));
    gsac_ram #(.DW(AW+DW), .AW(AW)) u_call (.i_clk, .i_we(ca_we), .i_waddr(ca_wa),
        .i_wdata(ca_wd), .i_raddr(ca_ra), .o_rdata(ca_rd));
    gsac_ram #(.DW(1), .AW(AW)) u_hin (.i_clk, .i_we(hi_we), .i_waddr(hi_wa),
        .i_wdata(hi_wd), .i_raddr(hi_ra), .o_rdata(hi_rd));
    gsac_ram #(.DW(1), .AW(AW)) u_hout (.i_clk, .i_we(ho_we), .i_waddr(ho_wa),
        .i_wdata(ho_wd), .i_raddr(ho_ra), .o_rdata(ho_rd));

    // neighbor of the frame cell in the frame direction
    logic [SW-1:0] u_row, u_col;
    logic          nb_ok;
    logic [AW-1:0] nb_t;

    assign u_row = r_u[AW-1:SW];
    assign u_col = r_u[SW-1:0];

    always_comb begin
        nb_ok = 1'b0;
        nb_t  = r_u;
        unique case (r_d)
            gsac_pkg::DIR_RIGHT: begin
                nb_ok = (u_col != i_dims.wlast);
                nb_t  = {u_row, u_col + SW'(1)};
            end
            gsac_pkg::DIR_LEFT: begin
                nb_ok = (u_col != '0);
                nb_t  = {u_row, u_col - SW'(1)};
            end
            gsac_pkg::DIR_DOWN: begin
                nb_ok = (u_row != i_dims.llast);
                nb_t  = {u_row + SW'(1), u_col};
            end
            gsac_pkg::DIR_UP: begin
                nb_ok = (u_row != '0);
                nb_t  = {u_row - SW'(1), u_col};
            end
            default: begin
                nb_ok = 1'b0;
            end
        endcase
    end

    logic          visit;
    logic [AW-1:0] visit_a;
    logic [CW-1:0] cs_top;

    always_comb begin
        n_st = r_st; n_srow = r_srow; n_scol = r_scol; n_sdone = r_sdone;
        n_cnt = r_cnt; n_ncomp = r_ncomp; n_sp = r_sp; n_cp = r_cp;
        n_ca = r_ca; n_p = r_p; n_q = r_q; n_lu = r_lu; n_cu = r_cu;
        n_u = r_u; n_v = r_v; n_d = r_d; n_hu = r_hu; n_need = r_need;
        visit = 1'b0; visit_a = r_v;
        cs_top = r_sp - CW'(1);

        h_we = i_load.we; h_wa = i_load.addr; h_wd = i_load.data; h_ra = r_u;
        dc_we = 1'b0; dc_wa = visit_a; dc_wd = '0; dc_ra = r_u;
        lo_we = 1'b0; lo_wa = r_u; lo_wd = r_lu; lo_ra = r_u;
        mk_we = 1'b0; mk_wa = r_ca[AW-1:0]; mk_wd = MARK_NEW; mk_ra = r_v;
        cm_we = 1'b0; cm_wa = r_v; cm_wd = r_ncomp - CW'(1); cm_ra = r_u;
        cs_we = 1'b0; cs_wa = r_sp[AW-1:0]; cs_wd = r_v; cs_ra = cs_top[AW-1:0];
        ca_we = 1'b0; ca_wa = '0; ca_wd = {r_u, r_d}; ca_ra = '0;
        hi_we = 1'b0; hi_wa = r_ca[AW-1:0]; hi_wd = 1'b0; hi_ra = r_ca[AW-1:0];
        ho_we = 1'b0; ho_wa = r_ca[AW-1:0]; ho_wd = 1'b0; ho_ra = r_ca[AW-1:0];

        unique case (r_st)
            S_IDLE: begin
                if (i_start) begin
                    n_ca = '0;
                    n_st = S_CLR;
                end
            end
            S_CLR: begin
                mk_we = 1'b1; hi_we = 1'b1; ho_we = 1'b1;
                n_ca  = r_ca + CW'(1);
                if (r_ca == CW'(gsac_pkg::CELLS - 1)) begin
                    n_srow = '0; n_scol = '0; n_sdone = 1'b0;
                    n_cnt = '0; n_ncomp = '0; n_sp = '0; n_cp = '0;
                    n_st = S_OUTER;
                end
            end
            S_OUTER: begin
                mk_ra = {r_srow, r_scol};
                if (r_sdone) begin
                    if (r_ncomp <= CW'(1)) begin
                        n_need = '0;
                        n_st   = S_OUT;
                    end else begin
                        n_u  = '0;
                        n_d  = gsac_pkg::DIR_RIGHT;
                        n_st = S_E0;
                    end
                end else begin
                    n_st = S_OUTER2;
                end
            end
            S_OUTER2: begin
                n_sdone = (r_scol == i_dims.wlast) && (r_srow == i_dims.llast);
                if (r_scol == i_dims.wlast) begin
                    n_scol = '0;
                    n_srow = r_srow + SW'(1);
                end else begin
                    n_scol = r_scol + SW'(1);
                end
                if (mk_rd == MARK_NEW) begin
                    visit   = 1'b1;
                    visit_a = {r_srow, r_scol};
                    n_u  = visit_a;
                    n_d  = gsac_pkg::DIR_RIGHT;
                    n_cp = CW'(1);
                    n_st = S_TOP;
                end else begin
                    n_st = S_OUTER;
                end
            end
            S_TOP: begin
                if (r_d == gsac_pkg::DIR_END) begin
                    n_st = S_P1;
                end else begin
                    n_d = r_d + DW'(1);
                    if (nb_ok) begin
                        n_v  = nb_t;
                        n_st = S_H1;
                    end
                end
            end
            S_H1: begin
                n_hu = h_rd;
                h_ra = r_v;
                n_st = S_H2;
            end
            S_H2: begin
                dc_ra = r_v;
                n_st  = (r_hu >= h_rd) ? S_V : S_TOP;
            end
            S_V: begin
                if (mk_rd == MARK_NEW) begin
                    visit   = 1'b1;
                    visit_a = r_v;
                    ca_we = 1'b1;
                    ca_wa = r_cp[AW-1:0] - AW'(1);
                    n_u  = r_v;
                    n_d  = gsac_pkg::DIR_RIGHT;
                    n_cp = r_cp + CW'(1);
                end else if (mk_rd == MARK_ON && dc_rd < lo_rd) begin
                    lo_we = 1'b1;
                    lo_wd = dc_rd;
                end
                n_st = S_TOP;
            end
            S_P1: begin
                n_lu = lo_rd;
                if (lo_rd == dc_rd) begin
                    n_ncomp = r_ncomp + CW'(1);
                    n_st    = S_POPC;
                end else begin
                    n_st = S_PAR;
                end
            end
            S_POPC: begin
                n_sp = cs_top;
                n_st = S_POPC2;
            end
            S_POPC2: begin
                mk_we = 1'b1; mk_wa = cs_rd; mk_wd = MARK_DONE;
                cm_we = 1'b1; cm_wa = cs_rd;
                n_st  = (cs_rd != r_u && r_sp != '0) ? S_POPC : S_PAR;
            end
            S_PAR: begin
                n_cp  = r_cp - CW'(1);
                ca_ra = r_cp[AW-1:0] - AW'(2);
                n_st  = (r_cp > CW'(1)) ? S_PAR2 : S_OUTER;
            end
            S_PAR2: begin
                n_u   = ca_rd[AW+DW-1:DW];
                n_d   = ca_rd[DW-1:0];
                lo_ra = ca_rd[AW+DW-1:DW];
                n_st  = S_PAR3;
            end
            S_PAR3: begin
                if (r_lu < lo_rd) begin
                    lo_we = 1'b1;
                end
                n_st = S_TOP;
            end
            S_E0: begin
                if (r_d == gsac_pkg::DIR_END) begin
                    n_d = gsac_pkg::DIR_RIGHT;
                    if (u_col == i_dims.wlast && u_row == i_dims.llast) begin
                        n_ca = '0; n_p = '0; n_q = '0;
                        n_st = S_CNT;
                    end else if (u_col == i_dims.wlast) begin
                        n_u = {u_row + SW'(1), SW'(0)};
                    end else begin
                        n_u = {u_row, u_col + SW'(1)};
                    end
                end else begin
                    n_d = r_d + DW'(1);
                    if (nb_ok) begin
                        n_v  = nb_t;
                        n_st = S_E1;
                    end
                end
            end
            S_E1: begin
                n_hu = h_rd;
                n_cu = cm_rd;
                h_ra = r_v;
                cm_ra = r_v;
                n_st = S_E2;
            end
            S_E2: begin
                if (r_hu >= h_rd && r_cu != cm_rd) begin
                    hi_we = 1'b1; hi_wa = cm_rd[AW-1:0]; hi_wd = 1'b1;
                    ho_we = 1'b1; ho_wa = r_cu[AW-1:0];  ho_wd = 1'b1;
                end
                n_st = S_E0;
            end
            S_CNT: begin
                n_st = S_CNT2;
            end
            S_CNT2: begin
                n_p  = r_p + CW'(!hi_rd);
                n_q  = r_q + CW'(!ho_rd);
                n_ca = r_ca + CW'(1);
                if (n_ca == r_ncomp) begin
                    n_need = (n_p > n_q) ? n_p : n_q;
                    n_st   = S_OUT;
                end else begin
                    n_st = S_CNT;
                end
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_st = S_IDLE;
                end
            end
            default: begin
                n_st = S_IDLE;
            end
        endcase

        if (visit) begin
            n_cnt = r_cnt + CW'(1);
            dc_we = 1'b1; dc_wa = visit_a; dc_wd = n_cnt;
            lo_we = 1'b1; lo_wa = visit_a; lo_wd = n_cnt;
            mk_we = 1'b1; mk_wa = visit_a; mk_wd = MARK_ON;
            cs_we = 1'b1; cs_wa = r_sp[AW-1:0]; cs_wd = visit_a;
            n_sp  = r_sp + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
        end else begin
            r_st <= n_st;
        end
        r_srow <= n_srow; r_scol <= n_scol; r_sdone <= n_sdone;
        r_cnt <= n_cnt; r_ncomp <= n_ncomp; r_sp <= n_sp; r_cp <= n_cp;
        r_ca <= n_ca; r_p <= n_p; r_q <= n_q; r_lu <= n_lu; r_cu <= n_cu;
        r_u <= n_u; r_v <= n_v; r_d <= n_d; r_hu <= n_hu; r_need <= n_need;
    end

    assign o_busy            = (r_st != S_IDLE);
    assign o_valid           = (r_st == S_OUT);
    assign o_edges_needed    = gsac_pkg::FIELD_W'(r_need);
    assign o_component_count = gsac_pkg::FIELD_W'(r_ncomp);

`ifndef SYNTHESIS
    a_top_has_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_TOP || r_st == S_V) |-> (r_cp != '0))
        else $error("call stack empty while walking");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_POPC) |-> (r_sp != '0))
        else $error("component stack underflow");
    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != S_IDLE) |-> !i_load.we)
        else $error("height write while walking");
    a_out_from_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_st == S_OUT) |-> ($past(r_st) == S_OUTER || $past(r_st) == S_CNT2))
        else $error("result raised from wrong step");
`endif

endmodule
